// ===== hdl/mdf_pkg.sv =====
package mdf_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int COEFF_W     = 16;
  localparam int COEFF_IDX_W = 4;
  localparam int CHAN_W      = 3;
  localparam int FILT_W      = 40;
  localparam int OSC_W       = 5;
  localparam int NORM_W      = 15;
  localparam int FRAC_W      = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam int NUM_CHANNELS_DEF   = 8;
  localparam int MAX_OVERSAMPLE_DEF = 16;

  localparam logic [OSC_W-1:0]  OSC_RESET  = OSC_W'(8);
  localparam logic [NORM_W-1:0] NORM_RESET = NORM_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NORM       = CFG_IDX_W'(1);

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== hdl/mdf_if.sv =====
interface mdf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic [mdf_pkg::SAMPLE_W-1:0]           sample;
  logic [mdf_pkg::COEFF_IDX_W-1:0]        coeff_index;
  logic signed [mdf_pkg::COEFF_W-1:0]     coeff_value;

  modport source (output valid, req_type, sample, coeff_index, coeff_value, input ready);
  modport sink (input valid, req_type, sample, coeff_index, coeff_value, output ready);
endinterface

interface mdf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mdf_pkg::CHAN_W-1:0]           channel;
  logic signed [mdf_pkg::FILT_W-1:0]    filtered;
  logic                                 last;

  modport source (output valid, channel, filtered, last, input ready);
  modport sink (input valid, channel, filtered, last, output ready);
endinterface

interface mdf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mdf_pkg::CFG_IDX_W-1:0]      index;
  logic [mdf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/multichannel_decimating_fir_top.sv =====
// Channel  Direction  Accepted when        Carries
// in_i     sink       valid && ready       req_type, sample, coeff_index, coeff_value
// out_o    source     valid && ready       channel, filtered, last
// cfg_i    sink       valid && ready       index, data
//
// A coefficient write is stored when it is accepted. A sample goes through the
// bit-serial multiply-accumulate, one sample bit per cycle. A sample that
// closes a block then runs the restoring divider, one quotient bit per cycle.
// Reset clears the channel sums, loads ones into the coefficient table and
// sets both registers to 8. A result waits in the output register without
// blocking input; a later block result stalls only while that register is full.
module multichannel_decimating_fir_top #(
  parameter int NUM_CHANNELS   = mdf_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_OVERSAMPLE = mdf_pkg::MAX_OVERSAMPLE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mdf_in_if.sink     in_i,
  mdf_out_if.source  out_o,
  mdf_cfg_if.sink    cfg_i
);

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int FRAME_W = (MAX_OVERSAMPLE > 1) ? $clog2(MAX_OVERSAMPLE) : 1;
  localparam int SUM_W   = 30 + FRAME_W;
  localparam int CNT_W   = (FRAME_W + 1 > mdf_pkg::OSC_W) ? FRAME_W + 1 : mdf_pkg::OSC_W;

  mdf_pkg::state_e                       state_q, state_d;
  logic [CH_W-1:0]                       chan_pos_q;
  logic [FRAME_W-1:0]                    frame_pos_q;
  logic [CH_W-1:0]                       ch_q;
  logic                                  final_q;
  logic signed [SUM_W-1:0]               sums_q [NUM_CHANNELS];
  logic signed [mdf_pkg::COEFF_W-1:0]    coeff_q [MAX_OVERSAMPLE];
  logic [mdf_pkg::OSC_W-1:0]             osc_q;
  logic [mdf_pkg::NORM_W-1:0]            norm_q;
  logic                                  out_valid_q;
  logic [mdf_pkg::CHAN_W-1:0]            out_chan_q;
  logic signed [mdf_pkg::FILT_W-1:0]     out_filt_q;
  logic                                  out_last_q;

  logic                                  in_acc;
  logic                                  samp_acc;
  logic                                  coeff_acc;
  logic                                  out_free;
  logic                                  mul_start;
  logic                                  div_start;
  logic                                  out_load;
  logic                                  sum_write;
  mdf_pkg::unit_status_t                 mul_st;
  mdf_pkg::unit_status_t                 div_st;
  logic signed [SUM_W-1:0]               mul_acc;
  logic signed [mdf_pkg::FILT_W-1:0]     div_res;
  logic [CNT_W-1:0]                      eff_count;
  logic                                  is_final;
  logic                                  chan_wrap;
  logic [mdf_pkg::NORM_W-1:0]            divisor;

  assign in_acc    = in_i.valid && in_i.ready;
  assign samp_acc  = in_acc && (in_i.req_type == mdf_pkg::REQ_SAMPLE);
  assign coeff_acc = in_acc && (in_i.req_type == mdf_pkg::REQ_COEFF);
  assign out_free  = !out_valid_q || out_o.ready;

  always_comb begin
    if (osc_q == '0) begin
      eff_count = CNT_W'(1);
    end else if (CNT_W'(osc_q) > CNT_W'(MAX_OVERSAMPLE)) begin
      eff_count = CNT_W'(MAX_OVERSAMPLE);
    end else begin
      eff_count = CNT_W'(osc_q);
    end
  end

  assign is_final  = (CNT_W'(frame_pos_q) + CNT_W'(1)) >= eff_count;
  assign chan_wrap = (chan_pos_q == CH_W'(NUM_CHANNELS - 1));
  assign divisor   = (norm_q == '0) ? mdf_pkg::NORM_W'(1) : norm_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdf_pkg::ST_IDLE: begin
        if (samp_acc) begin
          state_d = mdf_pkg::ST_MUL;
        end
      end
      mdf_pkg::ST_MUL: begin
        if (mul_st.done) begin
          state_d = final_q ? mdf_pkg::ST_DIV : mdf_pkg::ST_IDLE;
        end
      end
      mdf_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_d = out_free ? mdf_pkg::ST_IDLE : mdf_pkg::ST_HOLD;
        end
      end
      mdf_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = mdf_pkg::ST_IDLE;
        end
      end
      default: state_d = mdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sum_write  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      mdf_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        mul_start  = samp_acc;
      end
      mdf_pkg::ST_MUL: begin
        sum_write = mul_st.done;
        div_start = mul_st.done && final_q;
      end
      mdf_pkg::ST_DIV: begin
        out_load = div_st.done && out_free;
      end
      mdf_pkg::ST_HOLD: begin
        out_load = out_free;
      end
      default: begin
        in_i.ready = 1'b0;
      end
    endcase
  end

  mdf_mul #(
    .SUM_W (SUM_W)
  ) u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_start),
    .acc_init_i (sums_q[chan_pos_q]),
    .sample_i   (in_i.sample),
    .coeff_i    (coeff_q[frame_pos_q]),
    .status_o   (mul_st),
    .acc_o      (mul_acc)
  );

  mdf_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (mul_acc),
    .divisor_i (divisor),
    .status_o  (div_st),
    .result_o  (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdf_pkg::ST_IDLE;
      chan_pos_q  <= '0;
      frame_pos_q <= '0;
      ch_q        <= '0;
      final_q     <= 1'b0;
      osc_q       <= mdf_pkg::OSC_RESET;
      norm_q      <= mdf_pkg::NORM_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        sums_q[i] <= '0;
      end
      for (int i = 0; i < MAX_OVERSAMPLE; i++) begin
        coeff_q[i] <= mdf_pkg::COEFF_W'(1);
      end
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == mdf_pkg::REG_OVERSAMPLE) begin
          osc_q <= cfg_i.data[mdf_pkg::OSC_W-1:0];
        end else if (cfg_i.index == mdf_pkg::REG_NORM) begin
          norm_q <= cfg_i.data[mdf_pkg::NORM_W-1:0];
        end
      end
      if (coeff_acc && (int'(in_i.coeff_index) < MAX_OVERSAMPLE)) begin
        coeff_q[FRAME_W'(in_i.coeff_index)] <= in_i.coeff_value;
      end
      if (samp_acc) begin
        ch_q    <= chan_pos_q;
        final_q <= is_final;
        if (chan_wrap) begin
          chan_pos_q  <= '0;
          frame_pos_q <= is_final ? '0 : frame_pos_q + FRAME_W'(1);
        end else begin
          chan_pos_q <= chan_pos_q + CH_W'(1);
        end
      end
      if (sum_write) begin
        sums_q[ch_q] <= final_q ? '0 : mul_acc;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q <= mdf_pkg::CHAN_W'(ch_q);
      out_filt_q <= div_res;
      out_last_q <= (ch_q == CH_W'(NUM_CHANNELS - 1));
    end
  end

  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.channel  = out_chan_q;
  assign out_o.filtered = out_filt_q;
  assign out_o.last     = out_last_q;

`ifndef SYNTH
  a_idle_units_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!mul_st.busy && !div_st.busy))
    else $error("Input is ready while an arithmetic unit is busy.");

  a_frame_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(frame_pos_q) < MAX_OVERSAMPLE)
    else $error("Frame position is beyond the coefficient table.");

  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_st.done |-> (state_q == mdf_pkg::ST_MUL))
    else $error("Multiplier finished outside the multiply state.");

  a_div_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> final_q)
    else $error("Divider runs for an item that does not close a block.");

  a_hold_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdf_pkg::ST_HOLD) |-> out_valid_q)
    else $error("Result held back while the output register is empty.");
`endif

endmodule

// ===== hdl/mdf_mul.sv =====
module mdf_mul #(
  parameter int SUM_W = 34
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SUM_W-1:0]             acc_init_i,
  input  logic [mdf_pkg::SAMPLE_W-1:0]        sample_i,
  input  logic signed [mdf_pkg::COEFF_W-1:0]  coeff_i,
  output mdf_pkg::unit_status_t               status_o,
  output logic signed [SUM_W-1:0]             acc_o
);

  localparam int CNT_W = $clog2(mdf_pkg::SAMPLE_W);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic signed [SUM_W-1:0]          acc_q, acc_d;
  logic signed [SUM_W-1:0]          mcand_q, mcand_d;
  logic [mdf_pkg::SAMPLE_W-1:0]     mplier_q, mplier_d;
  logic                             last_step;

  assign last_step = (cnt_q == CNT_W'(mdf_pkg::SAMPLE_W - 1));

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = acc_init_i;
      mcand_d  = {{(SUM_W - mdf_pkg::COEFF_W){coeff_i[mdf_pkg::COEFF_W-1]}}, coeff_i};
      mplier_d = sample_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + CNT_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign acc_o         = acc_q;

endmodule

// ===== hdl/mdf_div.sv =====
module mdf_div #(
  parameter int SUM_W = 34
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [SUM_W-1:0]            sum_i,
  input  logic [mdf_pkg::NORM_W-1:0]         divisor_i,
  output mdf_pkg::unit_status_t              status_o,
  output logic signed [mdf_pkg::FILT_W-1:0]  result_o
);

  localparam int DVD_W = SUM_W + mdf_pkg::FRAC_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int EXT_W = (DVD_W > mdf_pkg::FILT_W) ? DVD_W + 1 : mdf_pkg::FILT_W + 1;
  localparam int NW    = mdf_pkg::NORM_W;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DVD_W-1:0]       dvd_q, dvd_d;
  logic [DVD_W-1:0]       quo_q, quo_d;
  logic [NW-1:0]          rem_q, rem_d;
  logic [NW-1:0]          divisor_q, divisor_d;
  logic                   neg_q, neg_d;
  logic [SUM_W-1:0]       mag;
  logic [NW:0]            trial;
  logic [NW:0]            diff;
  logic                   fits;
  logic [EXT_W-1:0]       q_ext;
  logic [EXT_W-1:0]       q_neg;
  logic [EXT_W-1:0]       lim_pos;
  logic [EXT_W-1:0]       lim_neg;

  assign mag   = sum_i[SUM_W-1] ? (~sum_i + SUM_W'(1)) : sum_i;
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    neg_d     = neg_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      dvd_d     = {mag, {mdf_pkg::FRAC_W{1'b0}}};
      quo_d     = '0;
      rem_d     = '0;
      divisor_d = divisor_i;
      neg_d     = sum_i[SUM_W-1];
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? diff[NW-1:0] : trial[NW-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    neg_q     <= neg_d;
  end

  assign q_ext   = EXT_W'(quo_q);
  assign q_neg   = ~q_ext + EXT_W'(1);
  assign lim_pos = EXT_W'({1'b0, {(mdf_pkg::FILT_W - 1){1'b1}}});
  assign lim_neg = EXT_W'({1'b1, {(mdf_pkg::FILT_W - 1){1'b0}}});

  always_comb begin
    if (neg_q) begin
      if (q_ext > lim_neg) begin
        result_o = {1'b1, {(mdf_pkg::FILT_W - 1){1'b0}}};
      end else begin
        result_o = q_neg[mdf_pkg::FILT_W-1:0];
      end
    end else begin
      if (q_ext > lim_pos) begin
        result_o = {1'b0, {(mdf_pkg::FILT_W - 1){1'b1}}};
      end else begin
        result_o = q_ext[mdf_pkg::FILT_W-1:0];
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== tb/multichannel_decimating_fir_top_test.sv =====
module multichannel_decimating_fir_top_test;

  localparam int NCH = mdf_pkg::NUM_CHANNELS_DEF;
  localparam int NOS = mdf_pkg::MAX_OVERSAMPLE_DEF;
  localparam int TOTAL_ITEMS = 1050;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [mdf_pkg::CFG_IDX_W-1:0] REG_SPARE = mdf_pkg::CFG_IDX_W'(2);
  localparam longint FILT_MAX = (longint'(1) <<< (mdf_pkg::FILT_W - 1)) - 1;
  localparam longint FILT_MIN = -(longint'(1) <<< (mdf_pkg::FILT_W - 1));

  typedef struct packed {
    logic [mdf_pkg::CHAN_W-1:0]        channel;
    logic signed [mdf_pkg::FILT_W-1:0] filtered;
    logic                              last;
  } fir_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mdf_in_if  in_if ();
  mdf_out_if out_if ();
  mdf_cfg_if cfg_if ();

  multichannel_decimating_fir_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  longint                             fir_sums [NCH];
  logic signed [mdf_pkg::COEFF_W-1:0] coeff_model [NOS];
  int unsigned                        slot_channel;
  int unsigned                        slot_frame;
  logic [mdf_pkg::OSC_W-1:0]          osc_reg;
  logic [mdf_pkg::NORM_W-1:0]         norm_reg;
  fir_result_t                        pending_results [$];
  int                                 errors = 0;
  int                                 items_sent = 0;
  int                                 burst_left = 0;
  int                                 rx_mode = 0;
  int                                 rx_mode_left = 0;
  int                                 rx_hold_left = 0;
  logic                               rx_hold_level = 1'b0;

  function automatic logic signed [mdf_pkg::FILT_W-1:0] scale_sum(longint sum);
    longint divisor;
    longint mag;
    longint q;
    divisor = (norm_reg == '0) ? longint'(1) : longint'(norm_reg);
    mag = (sum < 0) ? -sum : sum;
    q = (mag <<< mdf_pkg::FRAC_W) / divisor;
    if (sum < 0) q = -q;
    if (q > FILT_MAX) q = FILT_MAX;
    if (q < FILT_MIN) q = FILT_MIN;
    return q[mdf_pkg::FILT_W-1:0];
  endfunction

  function automatic void accumulate_sample(logic [mdf_pkg::SAMPLE_W-1:0] s);
    int unsigned frames;
    int unsigned ch;
    bit          closing;
    fir_result_t r;
    frames = (osc_reg == '0) ? 1 : ((osc_reg > NOS) ? NOS : int'(osc_reg));
    if (slot_channel >= NCH) slot_channel = 0;
    if (slot_frame >= NOS) slot_frame = 0;
    ch = slot_channel;
    closing = (slot_frame + 1 >= frames);
    fir_sums[ch] += longint'(s) * longint'(coeff_model[slot_frame]);
    if (closing) begin
      r.channel = mdf_pkg::CHAN_W'(ch);
      r.filtered = scale_sum(fir_sums[ch]);
      r.last = (ch == NCH - 1);
      pending_results.push_back(r);
      fir_sums[ch] = 0;
    end
    slot_channel = ch + 1;
    if (slot_channel >= NCH) begin
      slot_channel = 0;
      slot_frame = closing ? 0 : slot_frame + 1;
    end
  endfunction

  function automatic logic [mdf_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return mdf_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [mdf_pkg::COEFF_W-1:0] random_coeff();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3: return mdf_pkg::COEFF_W'(int'($urandom_range(0, 8)) - 4);
      default: return mdf_pkg::COEFF_W'($urandom);
    endcase
  endfunction

  function automatic logic [mdf_pkg::CFG_DATA_W-1:0] cfg_word(int unsigned value,
                                                             int unsigned width);
    logic [mdf_pkg::CFG_DATA_W-1:0] mask;
    mask = (mdf_pkg::CFG_DATA_W'(1) << width) - mdf_pkg::CFG_DATA_W'(1);
    return (($urandom_range(0, 1) != 0) ? (mdf_pkg::CFG_DATA_W'($urandom) & ~mask) : '0)
           | (mdf_pkg::CFG_DATA_W'(value) & mask);
  endfunction

  task automatic send_item(logic kind, logic [mdf_pkg::SAMPLE_W-1:0] s,
                           logic [mdf_pkg::COEFF_IDX_W-1:0] idx,
                           logic signed [mdf_pkg::COEFF_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.req_type <= kind;
    in_if.sample <= s;
    in_if.coeff_index <= idx;
    in_if.coeff_value <= val;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (kind == mdf_pkg::REQ_COEFF) begin
      coeff_model[idx] = val;
    end else begin
      accumulate_sample(s);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_sample(logic [mdf_pkg::SAMPLE_W-1:0] s);
    send_item(mdf_pkg::REQ_SAMPLE, s, mdf_pkg::COEFF_IDX_W'($urandom),
              mdf_pkg::COEFF_W'($urandom));
  endtask

  task automatic send_coeff(logic [mdf_pkg::COEFF_IDX_W-1:0] idx,
                            logic signed [mdf_pkg::COEFF_W-1:0] val);
    send_item(mdf_pkg::REQ_COEFF, mdf_pkg::SAMPLE_W'($urandom), idx, val);
  endtask

  task automatic write_reg(logic [mdf_pkg::CFG_IDX_W-1:0] idx,
                           logic [mdf_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    if (idx == mdf_pkg::REG_OVERSAMPLE) begin
      osc_reg = data[mdf_pkg::OSC_W-1:0];
    end else if (idx == mdf_pkg::REG_NORM) begin
      norm_reg = data[mdf_pkg::NORM_W-1:0];
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every block result has drained and the datapath has had
  // time to finish any sample that produces no result.
  task automatic settle_block();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_register_extremes();
    write_reg(mdf_pkg::REG_OVERSAMPLE, 16'd1);
    send_sample(12'd0);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(random_sample());
    send_coeff(mdf_pkg::COEFF_IDX_W'(0), 16'sh8000);
    send_coeff(mdf_pkg::COEFF_IDX_W'(NOS - 1), 16'sh7FFF);
    settle_block();
    write_reg(mdf_pkg::REG_NORM, 16'd1);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_coeff(mdf_pkg::COEFF_IDX_W'(0), 16'sh7FFF);
    settle_block();
    write_reg(mdf_pkg::REG_NORM, 16'h8000);
    write_reg(mdf_pkg::REG_OVERSAMPLE, 16'hFFE0);
    write_reg(REG_SPARE, 16'hFFFF);
    send_sample(12'hFFF);
    send_sample(12'd1);
    send_coeff(mdf_pkg::COEFF_IDX_W'(0), 16'shFFFF);
    settle_block();
    write_reg(mdf_pkg::REG_NORM, 16'hFFFF);
    send_sample(12'hFFF);
    send_sample(12'hABC);
    send_coeff(mdf_pkg::COEFF_IDX_W'(0), 16'sd1);
  endtask

  // Lowers the block length while a block is in progress, so the current
  // frame becomes the final one.
  task automatic test_block_shrink();
    int n;
    repeat (4) begin
      settle_block();
      write_reg(mdf_pkg::REG_OVERSAMPLE, cfg_word($urandom_range(3, 8), mdf_pkg::OSC_W));
      n = NCH * $urandom_range(1, 3) + $urandom_range(0, NCH - 1);
      repeat (n) send_sample(random_sample());
      settle_block();
      write_reg(mdf_pkg::REG_OVERSAMPLE,
                cfg_word($urandom_range(0, slot_frame), mdf_pkg::OSC_W));
      repeat (2 * NCH) send_sample(random_sample());
    end
  endtask

  task automatic test_random_traffic();
    int          phase;
    int          n;
    int unsigned osc_val;
    int unsigned norm_val;
    int          which;
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      settle_block();
      case ($urandom_range(0, 9))
        0: osc_val = 0;
        1: osc_val = 1;
        2: osc_val = 2;
        3: osc_val = NOS;
        4: osc_val = 31;
        5: osc_val = 8;
        default: osc_val = $urandom_range(0, 31);
      endcase
      case ($urandom_range(0, 7))
        0: norm_val = 0;
        1: norm_val = 1;
        2: norm_val = 32767;
        3: norm_val = $urandom_range(1, 255);
        default: norm_val = $urandom_range(0, 32767);
      endcase
      which = $urandom_range(0, 3);
      if (phase == 0) begin
        osc_val = NOS;
        norm_val = 1;
        which = 2;
      end else if (phase == 1) begin
        osc_val = 31;
        which = 2;
      end
      if (which != 1) write_reg(mdf_pkg::REG_OVERSAMPLE, cfg_word(osc_val, mdf_pkg::OSC_W));
      if (which != 0) write_reg(mdf_pkg::REG_NORM, cfg_word(norm_val, mdf_pkg::NORM_W));
      n = $urandom_range(16, 120);
      repeat (n) begin
        if (slot_channel == 0 && slot_frame == 0 && $urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_coeff(mdf_pkg::COEFF_IDX_W'($urandom), random_coeff());
          end
        end else if ($urandom_range(0, 39) == 0) begin
          send_coeff(mdf_pkg::COEFF_IDX_W'($urandom), random_coeff());
        end else begin
          send_sample(random_sample());
        end
      end
      phase++;
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    case (rx_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: begin
        if (rx_hold_left == 0) begin
          rx_hold_left = $urandom_range(1, 25);
          rx_hold_level = ~rx_hold_level;
        end
        rx_hold_left--;
        out_if.ready <= rx_hold_level;
      end
      default: out_if.ready <= (rx_mode_left % 3 == 0);
    endcase
  end

  always @(posedge clk_i) begin : result_check
    fir_result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: channel %0d, filtered %0d", out_if.channel, out_if.filtered);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.channel !== want.channel) begin
          $error("channel: expected %0d, actual %0d", want.channel, out_if.channel);
          errors++;
        end
        if (out_if.filtered !== want.filtered) begin
          $error("filtered: expected %0d, actual %0d", want.filtered, out_if.filtered);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_if.last);
          errors++;
        end
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = mdf_pkg::REQ_SAMPLE;
    in_if.sample = '0;
    in_if.coeff_index = '0;
    in_if.coeff_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    foreach (fir_sums[i]) fir_sums[i] = 0;
    foreach (coeff_model[i]) coeff_model[i] = 1;
    slot_channel = 0;
    slot_frame = 0;
    osc_reg = mdf_pkg::OSC_RESET;
    norm_reg = mdf_pkg::NORM_RESET;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_extremes();
    test_block_shrink();
    test_random_traffic();
    settle_block();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
